### hdl/rpc_pkg.sv
// ----------------------------------------------------------------------------
// rpc_pkg: shared types and constants of the rectangular/polar converter
// datapath widths, angle constants, arctangent table and cordic gain
// ----------------------------------------------------------------------------
package rpc_pkg;

  // default number of micro-rotations and fixed number of root digits
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int SQRT_STEPS       = 16;

  // cordic datapath: integer part, 16 fraction bits, growth headroom
  localparam int DW        = 36;
  localparam int FRAC_BITS = 16;
  // square-root remainder and partial root
  localparam int SQW       = 34;
  // inverse gain in q30
  localparam int GW        = 31;

  localparam logic signed [DW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [DW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [15:0]   PI_Q13      = 16'sd25736;
  localparam logic signed [16:0]   TWO_PI_Q13  = 17'sd51472;

  // form codes on the kind field
  localparam logic [1:0] KIND_RECT  = 2'd0;
  localparam logic [1:0] KIND_POLAR = 2'd1;

  // one word as it travels down the cell chain
  typedef struct packed {
    logic [1:0]           kind;
    logic signed [15:0]   a;
    logic signed [15:0]   b;
    logic signed [15:0]   ang;
    logic                 zero;
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] z;
    logic [SQW-1:0]       sq_v;
    logic [SQW-1:0]       sq_r;
  } rpc_word_t;

  // atan(2^-idx) in q30
  function automatic logic signed [DW-1:0] atan_q30(input int idx);
    logic signed [DW-1:0] r;
    r = '0;
    case (idx)
      0: r = 36'sd843314857;
      1: r = 36'sd497837829;
      2: r = 36'sd263043837;
      3: r = 36'sd133525159;
      4: r = 36'sd67021687;
      5: r = 36'sd33543516;
      6: r = 36'sd16775851;
      7: r = 36'sd8388437;
      8: r = 36'sd4194283;
      9: r = 36'sd2097149;
      default: begin
        if (idx >= 0 && idx <= 30) r[30-idx] = 1'b1;
      end
    endcase
    return r;
  endfunction

  // floor square root, elaboration only
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bitv;
    rem  = v;
    res  = '0;
    bitv = 64'h4000_0000_0000_0000;
    for (int k = 0; k < 32; k++) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // truncating long division, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int k = 63; k >= 0; k--) begin
      rem = {rem[63:0], num[k]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[k] = 1'b1;
      end
    end
    return quo;
  endfunction

  // inverse cordic gain in q30, one truncating quotient per micro-rotation
  function automatic logic signed [GW-1:0] inv_gain_q30(input int steps);
    logic [63:0] g;
    logic [63:0] root;
    g = 64'd1 << 30;
    for (int i = 0; i < 32; i++) begin
      if (i < steps) begin
        root = isqrt64((64'd1 << 60) + (64'd1 << (60 - 2 * i)));
        g    = udiv64(g << 30, root);
      end
    end
    return g[GW-1:0];
  endfunction

endpackage

### hdl/rpc_prep.sv
// ----------------------------------------------------------------------------
// rpc_prep: front end of the converter
// squares for the root, angle reduction, quadrant fold and cordic start vector
// ----------------------------------------------------------------------------
module rpc_prep (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic signed [15:0]  first_i,
  input  logic signed [15:0]  second_i,
  input  logic [1:0]          kind_i,
  output logic                valid_o,
  input  logic                ready_i,
  output rpc_pkg::rpc_word_t  word_o
);
  import rpc_pkg::*;

  // stage one
  logic               s1_valid_q;
  logic               s1_ready;
  logic [1:0]         kind_q;
  logic signed [15:0] a_q;
  logic signed [15:0] b_q;
  logic signed [15:0] ang_q;
  logic signed [15:0] ang_d;
  logic [30:0]        aa_q;
  logic [30:0]        bb_q;
  logic signed [31:0] aa_full;
  logic signed [31:0] bb_full;
  logic signed [16:0] b_ext;

  // stage two
  logic               s2_valid_q;
  logic               s2_ready;
  rpc_word_t          word_q;
  rpc_word_t          word_d;
  logic signed [DW-1:0] x_a;
  logic signed [DW-1:0] y_b;
  logic signed [DW-1:0] z_ang;

  assign s2_ready = !s2_valid_q || ready_i;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign ready_o  = s1_ready;

  assign aa_full = first_i * first_i;
  assign bb_full = second_i * second_i;
  assign b_ext   = {second_i[15], second_i};

  // wrap into the principal range
  always_comb begin
    ang_d = second_i;
    if (second_i > PI_Q13) begin
      ang_d = 16'(b_ext - TWO_PI_Q13);
    end else if (second_i < -PI_Q13) begin
      ang_d = 16'(b_ext + TWO_PI_Q13);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && valid_i) begin
      kind_q <= kind_i;
      a_q    <= first_i;
      b_q    <= second_i;
      ang_q  <= ang_d;
      aa_q   <= aa_full[30:0];
      bb_q   <= bb_full[30:0];
    end
  end

  assign x_a   = {{(DW-16-FRAC_BITS){a_q[15]}}, a_q, {FRAC_BITS{1'b0}}};
  assign y_b   = {{(DW-16-FRAC_BITS){b_q[15]}}, b_q, {FRAC_BITS{1'b0}}};
  assign z_ang = {{(DW-33){ang_q[15]}}, ang_q, 17'b0};

  always_comb begin
    word_d      = '0;
    word_d.kind = kind_q;
    word_d.a    = a_q;
    word_d.b    = b_q;
    word_d.ang  = ang_q;
    word_d.zero = (a_q == 16'sd0) && (b_q == 16'sd0);
    word_d.sq_v = SQW'(aa_q) + SQW'(bb_q);
    word_d.sq_r = '0;
    case (kind_q)
      KIND_RECT: begin
        // left half plane: rotate by pi first
        if (a_q[15]) begin
          word_d.x = -x_a;
          word_d.y = -y_b;
          word_d.z = b_q[15] ? -PI_Q30 : PI_Q30;
        end else begin
          word_d.x = x_a;
          word_d.y = y_b;
          word_d.z = '0;
        end
      end
      KIND_POLAR: begin
        word_d.y = '0;
        if (z_ang > HALF_PI_Q30) begin
          word_d.z = z_ang - PI_Q30;
          word_d.x = -x_a;
        end else if (z_ang < -HALF_PI_Q30) begin
          word_d.z = z_ang + PI_Q30;
          word_d.x = -x_a;
        end else begin
          word_d.z = z_ang;
          word_d.x = x_a;
        end
      end
      default: begin
        word_d.x = '0;
        word_d.y = '0;
        word_d.z = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      word_q <= word_d;
    end
  end

  assign valid_o = s2_valid_q;
  assign word_o  = word_q;

endmodule

### hdl/rpc_cell.sv
// ----------------------------------------------------------------------------
// rpc_cell: one link of the chain
// one cordic micro-rotation and one square-root digit at most, registered
// ----------------------------------------------------------------------------
module rpc_cell #(
  parameter int STEP_IDX     = 0,
  parameter int CORDIC_STEPS = rpc_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  rpc_pkg::rpc_word_t word_i,
  output logic               valid_o,
  input  logic               ready_i,
  output rpc_pkg::rpc_word_t word_o
);
  import rpc_pkg::*;

  localparam bit DO_ROT   = (STEP_IDX < CORDIC_STEPS);
  localparam bit DO_SQRT  = (STEP_IDX < SQRT_STEPS);
  localparam int SQ_SHIFT = DO_SQRT ? 2 * (SQRT_STEPS - 1 - STEP_IDX) : 0;
  localparam logic signed [DW-1:0] ATAN = atan_q30(STEP_IDX);
  localparam logic [SQW-1:0] SQ_BIT = {{(SQW-1){1'b0}}, 1'b1} << SQ_SHIFT;

  logic                 valid_q;
  logic                 ready;
  rpc_word_t            word_q;
  rpc_word_t            word_d;
  logic signed [DW-1:0] x_in;
  logic signed [DW-1:0] y_in;
  logic signed [DW-1:0] z_in;
  logic signed [DW-1:0] xs;
  logic signed [DW-1:0] ys;
  logic                 dir;
  logic [SQW-1:0]       trial;

  assign ready   = !valid_q || ready_i;
  assign ready_o = ready;

  assign x_in = word_i.x;
  assign y_in = word_i.y;
  assign z_in = word_i.z;
  assign xs   = x_in >>> STEP_IDX;
  assign ys   = y_in >>> STEP_IDX;
  // rotation mode steers on the residual angle, vectoring mode on y
  assign dir  = (word_i.kind == KIND_POLAR) ? z_in[DW-1] : !y_in[DW-1];
  assign trial = word_i.sq_r + SQ_BIT;

  always_comb begin
    word_d = word_i;
    if (DO_ROT) begin
      if (dir) begin
        word_d.x = x_in + ys;
        word_d.y = y_in - xs;
        word_d.z = z_in + ATAN;
      end else begin
        word_d.x = x_in - ys;
        word_d.y = y_in + xs;
        word_d.z = z_in - ATAN;
      end
    end
    if (DO_SQRT) begin
      if (word_i.sq_v >= trial) begin
        word_d.sq_v = word_i.sq_v - trial;
        word_d.sq_r = (word_i.sq_r >> 1) + SQ_BIT;
      end else begin
        word_d.sq_r = word_i.sq_r >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready && valid_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

### hdl/rpc_post.sv
// ----------------------------------------------------------------------------
// rpc_post: back end of the converter
// gain correction in split products, rounding, saturation and field select
// ----------------------------------------------------------------------------
module rpc_post #(
  parameter int CORDIC_STEPS = rpc_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  rpc_pkg::rpc_word_t word_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic signed [15:0] x_o,
  output logic signed [15:0] y_o,
  output logic signed [16:0] mag_o,
  output logic signed [15:0] ang_o,
  output logic               err_o
);
  import rpc_pkg::*;

  localparam logic signed [GW-1:0] INV_GAIN = inv_gain_q30(CORDIC_STEPS);
  localparam int XL_W  = DW / 2;
  localparam int XH_W  = DW - XL_W;
  localparam int PL_W  = XL_W + 1 + GW;
  localparam int PH_W  = XH_W + GW;
  localparam int SUM_W = DW + GW;
  localparam int OSH   = 30 + FRAC_BITS;
  localparam int RW    = SUM_W - OSH;
  localparam int ZSH   = 17;
  localparam int ZRW   = DW - ZSH;
  localparam logic signed [SUM_W-1:0] OHALF = {{(SUM_W-1){1'b0}}, 1'b1} << (OSH - 1);
  localparam logic signed [DW-1:0]    ZHALF = {{(DW-1){1'b0}}, 1'b1} << (ZSH - 1);

  // stage one: partial products, angle rounding, root rounding
  logic                   v1_q;
  logic                   r1;
  logic [1:0]             kind1_q;
  logic signed [15:0]     a1_q;
  logic signed [15:0]     ang1_q;
  logic                   zero1_q;
  logic signed [15:0]     b1_q;
  logic signed [PL_W-1:0] plx_q, ply_q, plx_d, ply_d;
  logic signed [PH_W-1:0] phx_q, phy_q, phx_d, phy_d;
  logic signed [ZRW-1:0]  zr1_q;
  logic signed [DW-1:0]   z_in;
  logic signed [DW-1:0]   z_rnd;
  logic signed [DW-1:0]   x_in;
  logic signed [DW-1:0]   y_in;
  logic [16:0]            mag1_q;
  logic [16:0]            mag_d;

  // stage two: product sums, angle clamp
  logic                    v2_q;
  logic                    r2;
  logic [1:0]              kind2_q;
  logic signed [15:0]      a2_q;
  logic signed [15:0]      b2_q;
  logic signed [15:0]      ang2_q;
  logic                    zero2_q;
  logic [16:0]             mag2_q;
  logic signed [SUM_W-1:0] sx_q, sy_q;
  logic signed [15:0]      za2_q;
  logic signed [15:0]      za_d;

  // stage three: output register
  logic                    v3_q;
  logic                    r3;
  logic signed [SUM_W-1:0] rx, ry;
  logic signed [RW-1:0]    qx, qy;
  logic signed [15:0]      satx, saty;
  logic signed [15:0]      x_q, y_q, ang_q, x_d, y_d, ang_d;
  logic signed [16:0]      mag_q, mag3_d;
  logic                    err_q, err_d;

  assign r3      = !v3_q || ready_i;
  assign r2      = !v2_q || r3;
  assign r1      = !v1_q || r2;
  assign ready_o = r1;

  assign x_in  = word_i.x;
  assign y_in  = word_i.y;
  assign z_in  = word_i.z;
  assign plx_d = $signed({1'b0, x_in[XL_W-1:0]}) * INV_GAIN;
  assign ply_d = $signed({1'b0, y_in[XL_W-1:0]}) * INV_GAIN;
  assign phx_d = $signed(x_in[DW-1:XL_W]) * INV_GAIN;
  assign phy_d = $signed(y_in[DW-1:XL_W]) * INV_GAIN;
  // round half away from zero: bias one less on the negative side
  assign z_rnd = z_in + (z_in[DW-1] ? ZHALF - 1 : ZHALF);
  // round root to nearest
  assign mag_d = word_i.sq_r[16:0] + {16'b0, (word_i.sq_v > word_i.sq_r)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (r1) v1_q <= valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1 && valid_i) begin
      kind1_q <= word_i.kind;
      a1_q    <= word_i.a;
      b1_q    <= word_i.b;
      ang1_q  <= word_i.ang;
      zero1_q <= word_i.zero;
      plx_q   <= plx_d;
      ply_q   <= ply_d;
      phx_q   <= phx_d;
      phy_q   <= phy_d;
      zr1_q   <= z_rnd[DW-1:ZSH];
      mag1_q  <= mag_d;
    end
  end

  always_comb begin
    za_d = zr1_q[15:0];
    if (zr1_q > ZRW'(PI_Q13)) begin
      za_d = PI_Q13;
    end else if (zr1_q < -ZRW'(PI_Q13)) begin
      za_d = -PI_Q13;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r2 && v1_q) begin
      kind2_q <= kind1_q;
      a2_q    <= a1_q;
      b2_q    <= b1_q;
      ang2_q  <= ang1_q;
      zero2_q <= zero1_q;
      mag2_q  <= mag1_q;
      sx_q    <= (SUM_W'(phx_q) <<< XL_W) + SUM_W'(plx_q);
      sy_q    <= (SUM_W'(phy_q) <<< XL_W) + SUM_W'(ply_q);
      za2_q   <= za_d;
    end
  end

  assign rx = sx_q + (sx_q[SUM_W-1] ? OHALF - 1 : OHALF);
  assign ry = sy_q + (sy_q[SUM_W-1] ? OHALF - 1 : OHALF);
  assign qx = rx[SUM_W-1:OSH];
  assign qy = ry[SUM_W-1:OSH];

  always_comb begin
    satx = qx[15:0];
    if (qx > RW'(16'sh7fff)) satx = 16'sh7fff;
    else if (qx < -RW'(17'sh08000)) satx = 16'sh8000;
    saty = qy[15:0];
    if (qy > RW'(16'sh7fff)) saty = 16'sh7fff;
    else if (qy < -RW'(17'sh08000)) saty = 16'sh8000;
  end

  always_comb begin
    x_d    = '0;
    y_d    = '0;
    mag3_d = '0;
    ang_d  = '0;
    err_d  = 1'b0;
    case (kind2_q)
      KIND_RECT: begin
        x_d    = a2_q;
        y_d    = b2_q;
        mag3_d = mag2_q;
        ang_d  = zero2_q ? 16'sd0 : za2_q;
      end
      KIND_POLAR: begin
        x_d    = satx;
        y_d    = saty;
        mag3_d = {a2_q[15], a2_q};
        ang_d  = ang2_q;
      end
      default: begin
        err_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (r3 && v2_q) begin
      x_q   <= x_d;
      y_q   <= y_d;
      mag_q <= mag3_d;
      ang_q <= ang_d;
      err_q <= err_d;
    end
  end

  assign valid_o = v3_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign mag_o   = mag_q;
  assign ang_o   = ang_q;
  assign err_o   = err_q;

endmodule

### hdl/rect_polar_converter.sv
// ----------------------------------------------------------------------------
// rect_polar_converter: rectangular/polar conversion by cordic cell chain
// x,y -> magnitude and atan2 angle, or magnitude,angle -> x,y (q3.13 angles)
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata (low bit up)                    | tuser
//  ---------+-----+---------------------------------------+------------------
//  s_axis   | in  | first_value[15:0], second_value[15:0] | kind[1:0]
//  m_axis   | out | x, y, magnitude(17), angle, 7 zero    | form_error
//
//  one word per cycle in and out while m_axis does not stall; the chain of
//  N = max(CORDIC_STEPS, 16) cells (each does up to one micro-rotation and one
//  root digit) lies between two front stages and three back stages
//  rst_ni clears every stage valid bit asynchronously; data registers keep
//  their contents
//  a stall on m_axis backs up stage by stage; empty stages keep filling, so
//  words are still taken while a result waits in the output register
//
module rect_polar_converter #(
  parameter int CORDIC_STEPS = rpc_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // first_value[15:0], second_value[31:16]
  input  logic [1:0]  s_axis_tuser_i,   // kind[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,   // x[15:0], y[31:16], magnitude[48:32],
                                        // angle[64:49], zero fill[71:65]
  output logic        m_axis_tuser_o    // form_error
);
  import rpc_pkg::*;

  // chain length covers both the rotations and the root digits
  localparam int N_CELLS = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;
  localparam int DEPTH   = N_CELLS + 5;
  localparam int CNT_W   = $clog2(DEPTH + 1);

  logic      chain_valid [N_CELLS+1];
  logic      chain_ready [N_CELLS+1];
  rpc_word_t chain_word  [N_CELLS+1];

  logic signed [15:0] res_x;
  logic signed [15:0] res_y;
  logic signed [16:0] res_mag;
  logic signed [15:0] res_ang;
  logic               res_err;

  // front end: squares, angle wrap, quadrant fold
  rpc_prep u_prep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid_i),
    .ready_o  (s_axis_tready_o),
    .first_i  (s_axis_tdata_i[15:0]),
    .second_i (s_axis_tdata_i[31:16]),
    .kind_i   (s_axis_tuser_i),
    .valid_o  (chain_valid[0]),
    .ready_i  (chain_ready[0]),
    .word_o   (chain_word[0])
  );

  // cell row, each step hands its word on to the next
  for (genvar gi = 0; gi < N_CELLS; gi++) begin : g_cell
    rpc_cell #(
      .STEP_IDX     (gi),
      .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[gi]),
      .ready_o (chain_ready[gi]),
      .word_i  (chain_word[gi]),
      .valid_o (chain_valid[gi+1]),
      .ready_i (chain_ready[gi+1]),
      .word_o  (chain_word[gi+1])
    );
  end

  // back end: gain correction and output register
  rpc_post #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (chain_valid[N_CELLS]),
    .ready_o (chain_ready[N_CELLS]),
    .word_i  (chain_word[N_CELLS]),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .x_o     (res_x),
    .y_o     (res_y),
    .mag_o   (res_mag),
    .ang_o   (res_ang),
    .err_o   (res_err)
  );

  assign m_axis_tdata_o = {7'b0, res_ang, res_mag, res_y, res_x};
  assign m_axis_tuser_o = res_err;

  // words in flight, for checking only
  logic [CNT_W-1:0] inflight_q;
  logic [CNT_W-1:0] inflight_d;
  logic             in_acc;
  logic             out_acc;

  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;

  always_comb begin
    inflight_d = inflight_q;
    if (in_acc && !out_acc) inflight_d = inflight_q + 1'b1;
    else if (out_acc && !in_acc) inflight_d = inflight_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // an invalid form carries an all-zero word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("form error word not zero");

  // angle stays within minus pi to pi
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (res_ang >= -PI_Q13) && (res_ang <= PI_Q13))
    else $error("angle out of range");

  // with the output register empty no stage can hold back the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output");

  // never more words inside than there are stages
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= CNT_W'(DEPTH))
    else $error("word count exceeds pipeline depth");

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for rect_polar_converter
// drives vectors into the stream input under random idling, predicts every
// result word in fixed point and compares it field by field at the output
// ----------------------------------------------------------------------------
module testbench;

  import rpc_pkg::*;

  // micro-rotations of the chain under test, and the stage count of the whole pipeline
  localparam int N_ROT        = 16;
  localparam int PIPE_LATENCY = 5 + N_ROT;

  // the two reserved form codes, both give the error flag
  localparam logic [1:0] KIND_RSVD_A = 2'd2;
  localparam logic [1:0] KIND_RSVD_B = 2'd3;

  localparam longint PI30     = PI_Q30;
  localparam longint HALFPI30 = HALF_PI_Q30;
  localparam longint PI13     = PI_Q13;
  localparam longint TWOPI13  = TWO_PI_Q13;

  // one expected result word
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [16:0] mag;
    logic signed [15:0] ang;
    logic               err;
  } conversion_t;

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [31:0] s_data = '0;    // first_value[15:0], second_value[31:16]
  logic [1:0]  s_user = '0;    // kind[1:0]
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [71:0] m_data;         // x[15:0], y[31:16], magnitude[48:32],
                               // angle[64:49], zero fill[71:65]
  logic        m_user;         // form_error

  conversion_t pending_results[$];
  int          error_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_req = 0;     // requested receiver hold-off, in cycles
  int          hold_left = 0;
  longint      inv_gain;         // inverse cordic gain, q30

  rect_polar_converter #(
    .CORDIC_STEPS(N_ROT)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // fixed-point predictor
  // --------------------------------------------------------------------------

  // atan(2^-k) in q30; past the tenth entry the angle equals its tangent
  function automatic longint arctan_step(int k);
    case (k)
      0: return 843314857;
      1: return 497837829;
      2: return 263043837;
      3: return 133525159;
      4: return 67021687;
      5: return 33543516;
      6: return 16775851;
      7: return 8388437;
      8: return 4194283;
      9: return 2097149;
      default: return (k <= 30) ? (longint'(1) << (30 - k)) : 0;
    endcase
  endfunction

  // floor square root, one result bit at a time from the top
  function automatic bit [63:0] root_floor(bit [63:0] v);
    bit [63:0] r;
    bit [63:0] t;
    r = '0;
    for (int k = 31; k >= 0; k--) begin
      t = r | (64'd1 << k);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // gain of n micro-rotations inverted, truncating each quotient
  function automatic longint cordic_inv_gain(int n);
    bit [63:0] g;
    g = 64'd1 << 30;
    for (int i = 0; i < n; i++)
      g = (g << 30) / root_floor((64'd1 << 60) + (64'd1 << (60 - 2 * i)));
    return longint'(g);
  endfunction

  // drop n bits, rounding half away from zero
  function automatic longint round_away(longint v, int n);
    longint half;
    half = longint'(1) << (n - 1);
    if (v >= 0) return (v + half) >>> n;
    return -((-v + half) >>> n);
  endfunction

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic conversion_t convert_vector(logic signed [15:0] first,
                                                 logic signed [15:0] second,
                                                 logic [1:0] form);
    conversion_t r;
    longint a, b, x, y, z, xs, ys, q;
    bit [63:0] sq, rt;
    r = '0;
    a = first;
    b = second;
    case (form)
      KIND_RECT: begin
        // length: exact root rounded to nearest
        sq = a * a + b * b;
        rt = root_floor(sq);
        if (sq - rt * rt > rt) rt = rt + 1;
        r.x   = first;
        r.y   = second;
        r.mag = rt[16:0];
        // zero vector keeps angle zero
        if (a != 0 || b != 0) begin
          x = a * 65536;
          y = b * 65536;
          z = 0;
          // left half-plane folded by pi, sign taken from y
          if (x < 0) begin
            z = (y >= 0) ? PI30 : -PI30;
            x = -x;
            y = -y;
          end
          for (int i = 0; i < N_ROT; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
              x = x + ys; y = y - xs; z = z + arctan_step(i);
            end else begin
              x = x - ys; y = y + xs; z = z - arctan_step(i);
            end
          end
          q = round_away(z, 17);
          if (q > PI13) q = PI13;
          if (q < -PI13) q = -PI13;
          r.ang = q[15:0];
        end
      end
      KIND_POLAR: begin
        // one wrap into the principal range
        q = b;
        if (q > PI13) q = q - TWOPI13;
        if (q < -PI13) q = q + TWOPI13;
        z = q * 131072;
        x = a * 65536;
        y = 0;
        // beyond a quarter turn: rotate by pi and negate the start vector
        if (z > HALFPI30) begin
          z = z - PI30; x = -x;
        end else if (z < -HALFPI30) begin
          z = z + PI30; x = -x;
        end
        for (int i = 0; i < N_ROT; i++) begin
          xs = x >>> i;
          ys = y >>> i;
          if (z >= 0) begin
            x = x - ys; y = y + xs; z = z - arctan_step(i);
          end else begin
            x = x + ys; y = y - xs; z = z + arctan_step(i);
          end
        end
        r.x   = 16'(clip16(round_away(x * inv_gain, 30 + FRAC_BITS)));
        r.y   = 16'(clip16(round_away(y * inv_gain, 30 + FRAC_BITS)));
        r.mag = a[16:0];
        r.ang = q[15:0];
      end
      default: r.err = 1'b1;
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // error reporting
  // --------------------------------------------------------------------------
  task automatic report_error(string msg);
    error_count++;
    $display("%0t ERROR %s", $time, msg);
  endtask

  task automatic check_field(string name, longint got, longint want);
    if (got != want)
      report_error($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // --------------------------------------------------------------------------
  // output side: ready pattern and result checking
  // --------------------------------------------------------------------------

  // receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // each accepted result word against the oldest prediction
  always @(posedge clk_i) begin : result_check
    conversion_t want;
    if (rst_n && m_valid && m_ready) begin
      if (pending_results.size() == 0) begin
        report_error("result word with no prediction pending");
      end else begin
        want = pending_results.pop_front();
        if ($isunknown(m_data) || $isunknown(m_user)) begin
          report_error($sformatf("unknown bits in result word %h %b", m_data, m_user));
        end else begin
          if (m_data[15:0] !== want.x)
            check_field("x", $signed(m_data[15:0]), want.x);
          if (m_data[31:16] !== want.y)
            check_field("y", $signed(m_data[31:16]), want.y);
          if (m_data[48:32] !== want.mag)
            check_field("magnitude", $signed(m_data[48:32]), want.mag);
          if (m_data[64:49] !== want.ang)
            check_field("angle", $signed(m_data[64:49]), want.ang);
          if (m_data[71:65] !== 7'd0)
            report_error($sformatf("zero fill got %b", m_data[71:65]));
          if (m_user !== want.err)
            report_error($sformatf("form_error got %b want %b", m_user, want.err));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // input side
  // --------------------------------------------------------------------------

  // offer one word; entered and left at a falling edge
  task automatic send_word(logic signed [15:0] first, logic signed [15:0] second,
                           logic [1:0] form);
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {second, first};
    s_user  <= form;
    do @(posedge clk_i); while (!s_ready);
    pending_results.push_back(convert_vector(first, second, form));
    @(negedge clk_i);
  endtask

  // stop offering until every predicted word has come out
  task automatic wait_drained();
    s_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  // full-range value with extra weight on the extremes
  function automatic logic [15:0] pick_value();
    case ($urandom_range(15))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      4: return 16'h0001;
      default: return 16'($urandom);
    endcase
  endfunction

  // angle, often close to the quarter-turn fold or the half-turn wrap
  function automatic logic [15:0] pick_angle();
    longint d;
    d = longint'($urandom_range(4)) - 2;
    case ($urandom_range(7))
      0: return 16'(PI13 + d);
      1: return 16'(-PI13 + d);
      2: return 16'(12868 + d);
      3: return 16'(-12868 + d);
      default: return pick_value();
    endcase
  endfunction

  function automatic logic [1:0] pick_reserved();
    return $urandom_range(1) ? KIND_RSVD_A : KIND_RSVD_B;
  endfunction

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // corners of both forms and both reserved codes
  task automatic test_directed();
    send_word(16'sd0, 16'sd0, KIND_RECT);             // zero vector
    send_word(16'sd32767, 16'sd0, KIND_RECT);
    send_word(-16'sd32768, 16'sd0, KIND_RECT);        // on the negative axis
    send_word(16'sd0, 16'sd32767, KIND_RECT);
    send_word(16'sd0, -16'sd32768, KIND_RECT);
    send_word(-16'sd32768, -16'sd32768, KIND_RECT);   // longest vector
    send_word(16'sd32767, 16'sd32767, KIND_RECT);
    send_word(-16'sd1, 16'sd0, KIND_RECT);
    send_word(-16'sd1, -16'sd1, KIND_RECT);
    send_word(16'sd1, -16'sd1, KIND_RECT);
    send_word(16'sd32767, 16'sd0, KIND_POLAR);
    send_word(-16'sd32768, 16'sd0, KIND_POLAR);       // negative full-scale start
    send_word(-16'sd32768, 16'sd25736, KIND_POLAR);
    send_word(16'sd32767, 16'sd25737, KIND_POLAR);    // wraps down by two pi
    send_word(16'sd32767, -16'sd25737, KIND_POLAR);   // wraps up by two pi
    send_word(16'sd32767, 16'sd32767, KIND_POLAR);
    send_word(16'sd32767, -16'sd32768, KIND_POLAR);
    send_word(16'sd20000, 16'sd12868, KIND_POLAR);    // just past a quarter turn
    send_word(16'sd20000, -16'sd12868, KIND_POLAR);
    send_word(16'sd32767, 16'sd6434, KIND_POLAR);
    send_word(-16'sd12345, 16'sd1000, KIND_POLAR);
    send_word(16'sd0, 16'sd25736, KIND_POLAR);
    send_word(16'sd32767, -16'sd32768, KIND_RSVD_A);
    send_word(-16'sd32768, 16'sd32767, KIND_RSVD_B);
  endtask

  task automatic test_rectangular(int n);
    for (int i = 0; i < n; i++) send_word(pick_value(), pick_value(), KIND_RECT);
  endtask

  task automatic test_polar(int n);
    for (int i = 0; i < n; i++) send_word(pick_value(), pick_angle(), KIND_POLAR);
  endtask

  // mixed forms, draining the block now and then
  task automatic test_mixed(int n);
    int sel;
    for (int i = 0; i < n; i++) begin
      if (i % 200 == 199) wait_drained();
      sel = $urandom_range(9);
      if (sel < 5) send_word(pick_value(), pick_value(), KIND_RECT);
      else if (sel < 9) send_word(pick_value(), pick_angle(), KIND_POLAR);
      else send_word(pick_value(), pick_value(), pick_reserved());
    end
  endtask

  // long receiver hold-off while words keep coming, so the chain fills up
  // and the input stalls
  task automatic test_receiver_hold();
    int saved;
    saved = send_idle_pct;
    send_idle_pct = 0;
    hold_req = 300;
    test_mixed(120);
    send_idle_pct = saved;
  endtask

  initial begin
    inv_gain = cordic_inv_gain(N_ROT);
    repeat (2) @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 25;
    recv_idle_pct = 67;
    test_directed();
    test_rectangular(300);
    test_polar(300);

    send_idle_pct = 67;
    recv_idle_pct = 25;
    test_mixed(550);
    test_receiver_hold();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_mixed(550);

    s_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #3000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

### files.f
hdl/rpc_pkg.sv
hdl/rpc_prep.sv
hdl/rpc_cell.sv
hdl/rpc_post.sv
hdl/rect_polar_converter.sv
verif/testbench.sv
